// ===== hw/rtl/pool_window_row_address_gen_top_macros.svh =====
// Assertion macros for the pool window row address generator.
// Used by the checker module; no other dependencies.
`ifndef POOL_WINDOW_ROW_ADDRESS_GEN_TOP_MACROS_SVH
`define POOL_WINDOW_ROW_ADDRESS_GEN_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pwr_pkg.sv =====
// Shared types and constants for the pool window row address generator.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps

package pwr_pkg;

  localparam int POS_W   = 10;  // output column / row position
  localparam int ROW_W   = 32;  // input row id
  localparam int CNT_W   = 7;   // item count within one window (up to 64)
  localparam int WIN_W   = 4;   // window side
  localparam int PAD_W   = 3;   // padding
  localparam int REG_W   = 11;  // widest configuration register
  localparam int DIM_W   = 13;  // clamped image dimension (covers MAX_DIM up to 4096)
  localparam int COORD_W = 16;  // signed window coordinate
  localparam int IDX_W   = 4;   // configuration register index

  localparam logic [IDX_W-1:0] REG_WINDOW_HEIGHT = 4'd0;
  localparam logic [IDX_W-1:0] REG_WINDOW_WIDTH  = 4'd1;
  localparam logic [IDX_W-1:0] REG_PAD_TOP       = 4'd2;
  localparam logic [IDX_W-1:0] REG_PAD_LEFT      = 4'd3;
  localparam logic [IDX_W-1:0] REG_INPUT_HEIGHT  = 4'd4;
  localparam logic [IDX_W-1:0] REG_INPUT_WIDTH   = 4'd5;
  localparam logic [IDX_W-1:0] REG_OUTPUT_HEIGHT = 4'd6;
  localparam logic [IDX_W-1:0] REG_OUTPUT_WIDTH  = 4'd7;

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_GENERATE = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_PAD  = 1'b1;

  // Configuration after range clamping.
  typedef struct packed {
    logic [WIN_W-1:0] wh;
    logic [WIN_W-1:0] ww;
    logic [PAD_W-1:0] pad_top;
    logic [PAD_W-1:0] pad_left;
    logic [DIM_W-1:0] ih;
    logic [DIM_W-1:0] iw;
    logic [DIM_W-1:0] oh;
    logic [DIM_W-1:0] ow;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROW,
    ST_EMIT,
    ST_PAD,
    ST_ADV,
    ST_BATCH
  } state_t;

endpackage

// ===== hw/rtl/pwr_mul_unit.sv =====
// Shared registered multiplier: input width times a selected operand.
// Depends on pwr_pkg for widths.
`timescale 1ns / 1ps

module pwr_mul_unit (
  input  logic                              clk,
  input  logic [pwr_pkg::DIM_W-1:0]         mul_a,
  input  logic [pwr_pkg::COORD_W-1:0]       mul_b,
  output logic [pwr_pkg::ROW_W-1:0]         prod_r
);

  logic [pwr_pkg::ROW_W-1:0] prod_nxt;

  assign prod_nxt = pwr_pkg::ROW_W'(mul_a) * pwr_pkg::ROW_W'(mul_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== hw/rtl/pwr_seq.sv =====
// Sequencer and address datapath: window bounds, row id walk, pad item,
// output register and position advance. Depends on pwr_pkg and pwr_mul_unit.
`timescale 1ns / 1ps

module pwr_seq #(
  parameter int ROW_STEP = 2,
  parameter int COL_STEP = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pwr_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [pwr_pkg::POS_W-1:0]     in_start_col,
  input  logic [pwr_pkg::POS_W-1:0]     in_start_row,
  input  logic [pwr_pkg::ROW_W-1:0]     in_start_base,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [pwr_pkg::ROW_W-1:0]     out_row_id,
  output logic [pwr_pkg::CNT_W-1:0]     out_pad_count,
  output logic                          out_last
);

  pwr_pkg::state_t state_r, state_nxt;

  logic [pwr_pkg::POS_W-1:0]          out_col_r, out_col_nxt;
  logic [pwr_pkg::POS_W-1:0]          out_row_r, out_row_nxt;
  logic [pwr_pkg::ROW_W-1:0]          batch_base_r, batch_base_nxt;

  logic signed [pwr_pkg::COORD_W-1:0] h_r, h_nxt, h_end_r, h_end_nxt;
  logic signed [pwr_pkg::COORD_W-1:0] w_r, w_nxt, w_start_r, w_start_nxt, w_end_r, w_end_nxt;
  logic [pwr_pkg::CNT_W-1:0]          n_r, n_nxt, full_r, full_nxt;
  logic                               empty_r, empty_nxt;
  logic [pwr_pkg::ROW_W-1:0]          row_addr_r, row_addr_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic                               out_kind_r, out_kind_nxt;
  logic [pwr_pkg::ROW_W-1:0]          out_row_id_r, out_row_id_nxt;
  logic [pwr_pkg::CNT_W-1:0]          out_pad_count_r, out_pad_count_nxt;
  logic                               out_last_r, out_last_nxt;

  logic signed [pwr_pkg::COORD_W-1:0] sh_raw, eh_raw, sw_raw, ew_raw;
  logic signed [pwr_pkg::COORD_W-1:0] sh_c, eh_c, sw_c, ew_c;
  logic [pwr_pkg::COORD_W-1:0]        mul_b;
  logic [pwr_pkg::ROW_W-1:0]          prod_r;
  logic                               out_free, in_xfer, row_done, last_read;
  logic [pwr_pkg::CNT_W-1:0]          cnt_inc;
  logic [pwr_pkg::POS_W:0]            next_col, next_row;

  pwr_mul_unit u_mul (
    .clk    (clk),
    .mul_a  (cfg.iw),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // The multiplier forms iw * first_row while the window is set up and
  // iw * ih while the batch base advances.
  assign mul_b = (state_r == pwr_pkg::ST_ADV) ? pwr_pkg::COORD_W'(cfg.ih)
                                              : pwr_pkg::COORD_W'(h_r);

  assign in_stall = (state_r != pwr_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Window bounds before and after clipping to the input image.
  always_comb begin
    sh_raw = signed'(pwr_pkg::COORD_W'(out_row_r) * pwr_pkg::COORD_W'(ROW_STEP)
                     - pwr_pkg::COORD_W'(cfg.pad_top));
    sw_raw = signed'(pwr_pkg::COORD_W'(out_col_r) * pwr_pkg::COORD_W'(COL_STEP)
                     - pwr_pkg::COORD_W'(cfg.pad_left));
    eh_raw = sh_raw + signed'(pwr_pkg::COORD_W'(cfg.wh));
    ew_raw = sw_raw + signed'(pwr_pkg::COORD_W'(cfg.ww));
    sh_c   = (sh_raw < 0) ? '0 : sh_raw;
    sw_c   = (sw_raw < 0) ? '0 : sw_raw;
    eh_c   = (eh_raw > signed'(pwr_pkg::COORD_W'(cfg.ih))) ?
             signed'(pwr_pkg::COORD_W'(cfg.ih)) : eh_raw;
    ew_c   = (ew_raw > signed'(pwr_pkg::COORD_W'(cfg.iw))) ?
             signed'(pwr_pkg::COORD_W'(cfg.iw)) : ew_raw;
  end

  assign row_done  = (w_r + 16'sd1 == w_end_r);
  assign last_read = row_done && (h_r + 16'sd1 == h_end_r);
  assign cnt_inc   = n_r + 7'd1;
  assign next_col  = {1'b0, out_col_r} + 11'd1;
  assign next_row  = {1'b0, out_row_r} + 11'd1;

  always_comb begin
    state_nxt         = state_r;
    out_col_nxt       = out_col_r;
    out_row_nxt       = out_row_r;
    batch_base_nxt    = batch_base_r;
    h_nxt             = h_r;
    h_end_nxt         = h_end_r;
    w_nxt             = w_r;
    w_start_nxt       = w_start_r;
    w_end_nxt         = w_end_r;
    n_nxt             = n_r;
    full_nxt          = full_r;
    empty_nxt         = empty_r;
    row_addr_nxt      = row_addr_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_kind_nxt      = out_kind_r;
    out_row_id_nxt    = out_row_id_r;
    out_pad_count_nxt = out_pad_count_r;
    out_last_nxt      = out_last_r;

    case (state_r)
      pwr_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_cmd == pwr_pkg::CMD_LOAD) begin
            out_col_nxt    = in_start_col;
            out_row_nxt    = in_start_row;
            batch_base_nxt = in_start_base;
          end else begin
            h_nxt       = sh_c;
            h_end_nxt   = eh_c;
            w_nxt       = sw_c;
            w_start_nxt = sw_c;
            w_end_nxt   = ew_c;
            n_nxt       = '0;
            full_nxt    = pwr_pkg::CNT_W'(cfg.wh) * pwr_pkg::CNT_W'(cfg.ww);
            empty_nxt   = (sh_c >= eh_c) || (sw_c >= ew_c);
            state_nxt   = pwr_pkg::ST_MUL;
          end
        end
      end
      pwr_pkg::ST_MUL: begin
        state_nxt = pwr_pkg::ST_ROW;
      end
      pwr_pkg::ST_ROW: begin
        row_addr_nxt = batch_base_r + prod_r;
        state_nxt    = empty_r ? pwr_pkg::ST_PAD : pwr_pkg::ST_EMIT;
      end
      pwr_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_kind_nxt      = pwr_pkg::KIND_READ;
          out_row_id_nxt    = row_addr_r + pwr_pkg::ROW_W'(unsigned'(w_r));
          out_pad_count_nxt = '0;
          out_last_nxt      = last_read && (cnt_inc == full_r);
          n_nxt             = cnt_inc;
          if (row_done) begin
            w_nxt        = w_start_r;
            h_nxt        = h_r + 16'sd1;
            row_addr_nxt = row_addr_r + pwr_pkg::ROW_W'(cfg.iw);
          end else begin
            w_nxt = w_r + 16'sd1;
          end
          if (last_read) begin
            state_nxt = (cnt_inc == full_r) ? pwr_pkg::ST_ADV : pwr_pkg::ST_PAD;
          end
        end
      end
      pwr_pkg::ST_PAD: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_kind_nxt      = pwr_pkg::KIND_PAD;
          out_row_id_nxt    = '0;
          out_pad_count_nxt = full_r - n_r;
          out_last_nxt      = 1'b1;
          state_nxt         = pwr_pkg::ST_ADV;
        end
      end
      pwr_pkg::ST_ADV: begin
        state_nxt = pwr_pkg::ST_IDLE;
        if (pwr_pkg::DIM_W'(next_col) >= cfg.ow) begin
          out_col_nxt = '0;
          if (pwr_pkg::DIM_W'(next_row) >= cfg.oh) begin
            out_row_nxt = '0;
            state_nxt   = pwr_pkg::ST_BATCH;
          end else begin
            out_row_nxt = next_row[pwr_pkg::POS_W-1:0];
          end
        end else begin
          out_col_nxt = next_col[pwr_pkg::POS_W-1:0];
        end
      end
      pwr_pkg::ST_BATCH: begin
        batch_base_nxt = batch_base_r + prod_r;
        state_nxt      = pwr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pwr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pwr_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      batch_base_r <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      out_col_r    <= out_col_nxt;
      out_row_r    <= out_row_nxt;
      batch_base_r <= batch_base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r             <= h_nxt;
    h_end_r         <= h_end_nxt;
    w_r             <= w_nxt;
    w_start_r       <= w_start_nxt;
    w_end_r         <= w_end_nxt;
    n_r             <= n_nxt;
    full_r          <= full_nxt;
    empty_r         <= empty_nxt;
    row_addr_r      <= row_addr_nxt;
    out_kind_r      <= out_kind_nxt;
    out_row_id_r    <= out_row_id_nxt;
    out_pad_count_r <= out_pad_count_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_row_id    = out_row_id_r;
  assign out_pad_count = out_pad_count_r;
  assign out_last      = out_last_r;

endmodule

// ===== hw/rtl/pool_window_row_address_gen_top.sv =====
// Channel     | Direction | Ports
// ------------+-----------+-----------------------------------------------------
// command     | in        | in_valid, in_stall, in_cmd, in_start_col/row/base
// row address | out       | out_valid, out_stall, out_kind, out_row_id,
//             |           | out_pad_count, out_last
// config      | in        | cfg_we, cfg_index, cfg_wdata (write only)
//
// A load command sets the start column, row and batch base. A generate command
// steps through MUL, ROW, the read items, a pad item if any, and ADV, plus BATCH
// when the batch wraps; the output register moves one item per cycle unless
// stalled, and the shared multiplier gives the first-row offset, then batch step.
// Reset is synchronous, active low; it restores register defaults and clears
// the position. A stall on the output holds the walk where it stands.
// Top level: configuration registers and clamping; depends on pwr_pkg and pwr_seq.
`timescale 1ns / 1ps

module pool_window_row_address_gen_top #(
  parameter int ROW_STEP        = 2,
  parameter int COL_STEP        = 2,
  parameter int MAX_WINDOW_SIDE = 8,
  parameter int MAX_DIM         = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [pwr_pkg::POS_W-1:0]     in_start_col,
  input  logic [pwr_pkg::POS_W-1:0]     in_start_row,
  input  logic [pwr_pkg::ROW_W-1:0]     in_start_base,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [pwr_pkg::ROW_W-1:0]     out_row_id,
  output logic [pwr_pkg::CNT_W-1:0]     out_pad_count,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [pwr_pkg::IDX_W-1:0]     cfg_index,
  input  logic [pwr_pkg::REG_W-1:0]     cfg_wdata
);

  logic [pwr_pkg::WIN_W-1:0] wh_r, ww_r;
  logic [pwr_pkg::PAD_W-1:0] pad_top_r, pad_left_r;
  logic [pwr_pkg::REG_W-1:0] ih_r, iw_r, oh_r, ow_r;
  pwr_pkg::cfg_t             cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wh_r       <= 4'd2;
      ww_r       <= 4'd2;
      pad_top_r  <= '0;
      pad_left_r <= '0;
      ih_r       <= 11'd1;
      iw_r       <= 11'd1;
      oh_r       <= 11'd1;
      ow_r       <= 11'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        pwr_pkg::REG_WINDOW_HEIGHT: wh_r       <= cfg_wdata[pwr_pkg::WIN_W-1:0];
        pwr_pkg::REG_WINDOW_WIDTH:  ww_r       <= cfg_wdata[pwr_pkg::WIN_W-1:0];
        pwr_pkg::REG_PAD_TOP:       pad_top_r  <= cfg_wdata[pwr_pkg::PAD_W-1:0];
        pwr_pkg::REG_PAD_LEFT:      pad_left_r <= cfg_wdata[pwr_pkg::PAD_W-1:0];
        pwr_pkg::REG_INPUT_HEIGHT:  ih_r       <= cfg_wdata;
        pwr_pkg::REG_INPUT_WIDTH:   iw_r       <= cfg_wdata;
        pwr_pkg::REG_OUTPUT_HEIGHT: oh_r       <= cfg_wdata;
        pwr_pkg::REG_OUTPUT_WIDTH:  ow_r       <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Out-of-range settings are pulled into their legal range.
  function automatic logic [pwr_pkg::DIM_W-1:0] clamp_dim(input logic [pwr_pkg::REG_W-1:0] v);
    logic [pwr_pkg::DIM_W-1:0] ext;
    ext = pwr_pkg::DIM_W'(v);
    if (v == '0) begin
      clamp_dim = pwr_pkg::DIM_W'(1);
    end else if (ext > pwr_pkg::DIM_W'(MAX_DIM)) begin
      clamp_dim = pwr_pkg::DIM_W'(MAX_DIM);
    end else begin
      clamp_dim = ext;
    end
  endfunction

  function automatic logic [pwr_pkg::WIN_W-1:0] clamp_win(input logic [pwr_pkg::WIN_W-1:0] v);
    if (v == '0) begin
      clamp_win = pwr_pkg::WIN_W'(1);
    end else if (v > pwr_pkg::WIN_W'(MAX_WINDOW_SIDE)) begin
      clamp_win = pwr_pkg::WIN_W'(MAX_WINDOW_SIDE);
    end else begin
      clamp_win = v;
    end
  endfunction

  always_comb begin
    cfg.wh       = clamp_win(wh_r);
    cfg.ww       = clamp_win(ww_r);
    cfg.pad_top  = pad_top_r;
    cfg.pad_left = pad_left_r;
    cfg.ih       = clamp_dim(ih_r);
    cfg.iw       = clamp_dim(iw_r);
    cfg.oh       = clamp_dim(oh_r);
    cfg.ow       = clamp_dim(ow_r);
  end

  pwr_seq #(
    .ROW_STEP (ROW_STEP),
    .COL_STEP (COL_STEP)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_start_col  (in_start_col),
    .in_start_row  (in_start_row),
    .in_start_base (in_start_base),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_row_id    (out_row_id),
    .out_pad_count (out_pad_count),
    .out_last      (out_last)
  );

endmodule

// ===== hw/rtl/pwr_checker.sv =====
// Port-level checker for the pool window row address generator, with its bind.
// Depends on pwr_pkg and pool_window_row_address_gen_top_macros.svh.
`timescale 1ns / 1ps
`include "pool_window_row_address_gen_top_macros.svh"

module pwr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_kind,
  input logic [pwr_pkg::ROW_W-1:0]     out_row_id,
  input logic [pwr_pkg::CNT_W-1:0]     out_pad_count,
  input logic                          out_last
);

  // A pad item always closes its window.
  `PWR_ASSERT_NOW(a_pad_is_last, clk, rst_n,
    out_valid && (out_kind == pwr_pkg::KIND_PAD), out_last,
    "pad item without last flag")

  // A pad item fills between one and a full 8x8 window of rows and has no row id.
  `PWR_ASSERT_NOW(a_pad_count_range, clk, rst_n,
    out_valid && (out_kind == pwr_pkg::KIND_PAD),
    (out_pad_count != 7'd0) && (out_pad_count <= 7'd64) && (out_row_id == 32'd0),
    "pad item fields out of range")

  // A read item carries no pad count.
  `PWR_ASSERT_NOW(a_read_no_pad, clk, rst_n,
    out_valid && (out_kind == pwr_pkg::KIND_READ), out_pad_count == 7'd0,
    "read item with pad count")

  // A stalled result item holds until its transfer.
  `PWR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_row_id) && $stable(out_kind) && $stable(out_last),
    "stalled result changed")

endmodule

bind pool_window_row_address_gen_top pwr_checker u_pwr_checker (.*);
